FILE: hw/rtl/tpe_pkg.sv
// Package of the thick polyline extruder: shared types, constants, the
// vertex write sequence table and the coordinate saturation function.
// Depends on nothing; the modules of the block and its testbench import it.
package tpe_pkg;

   // Default capacity of the point store.
   localparam int unsigned MAX_POINTS_DEFAULT = 256;

   // Depth of the job queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DEFAULT_COLOR     = 2'd0;
   localparam logic [1:0] CSR_LINE_THICKNESS    = 2'd1;
   localparam logic [1:0] CSR_OUTLINE_THICKNESS = 2'd2;
   localparam logic [1:0] CSR_OUTLINE_COLOR     = 2'd3;

   // Index of the first vertex write after the previous-joint patches and
   // index of the last vertex write of a full request.
   localparam logic [4:0] WR_FIRST_SECTION = 5'd4;
   localparam logic [4:0] WR_LAST          = 5'd27;

   // Vertex groups: previous joint, section, next joint.
   localparam logic [1:0] GRP_PREV_JOINT = 2'd0;
   localparam logic [1:0] GRP_SECTION    = 2'd1;
   localparam logic [1:0] GRP_NEXT_JOINT = 2'd2;

   // Saturation bounds of a Q15.8 coordinate.
   localparam logic signed [25:0] POS_MAX = 26'sd8388607;
   localparam logic signed [25:0] POS_MIN = -26'sd8388608;

   typedef logic signed [23:0] pos_type;
   typedef logic [1:0]         csr_index_type;

   typedef enum logic [1:0] {
      CSEL_NONE,
      CSEL_PREV,
      CSEL_POINT,
      CSEL_OUTLINE
   } csel_type;

   // One segment job handed from the front to the back.
   typedef struct packed {
      pos_type            ax;
      pos_type            ay;
      pos_type            bx;
      pos_type            by;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic [49:0]        l2;
      logic [15:0]        ra;
      logic [15:0]        rb;
      logic [31:0]        a_color;
      logic [31:0]        b_color;
      logic [11:0]        idx;
      logic               patch;
   } job_type;

   // Description of one vertex write.
   typedef struct packed {
      logic       layer;
      logic [1:0] grp;
      logic [2:0] k;
      logic       use_b;
      logic       plus;
      csel_type   csel;
   } wr_desc_type;

   // The fixed order of vertex writes of one segment.
   function automatic wr_desc_type wr_desc(input logic [4:0] w);
      wr_desc_type d;
      d = '{layer: 1'b0, grp: GRP_SECTION, k: 3'd0, use_b: 1'b0, plus: 1'b0,
            csel: CSEL_NONE};
      case (w)
         5'd0: d = '{1'b0, GRP_PREV_JOINT, 3'd0, 1'b0, 1'b1, CSEL_NONE};
         5'd1: d = '{1'b0, GRP_PREV_JOINT, 3'd5, 1'b0, 1'b0, CSEL_NONE};
         5'd2: d = '{1'b1, GRP_PREV_JOINT, 3'd0, 1'b0, 1'b1, CSEL_NONE};
         5'd3: d = '{1'b1, GRP_PREV_JOINT, 3'd5, 1'b0, 1'b0, CSEL_NONE};
         5'd4: d = '{1'b0, GRP_SECTION, 3'd0, 1'b0, 1'b0, CSEL_PREV};
         5'd5: d = '{1'b0, GRP_SECTION, 3'd1, 1'b0, 1'b1, CSEL_PREV};
         5'd6: d = '{1'b0, GRP_SECTION, 3'd2, 1'b1, 1'b1, CSEL_POINT};
         5'd7: d = '{1'b0, GRP_SECTION, 3'd3, 1'b0, 1'b0, CSEL_PREV};
         5'd8: d = '{1'b0, GRP_SECTION, 3'd4, 1'b1, 1'b1, CSEL_POINT};
         5'd9: d = '{1'b0, GRP_SECTION, 3'd5, 1'b1, 1'b0, CSEL_POINT};
         5'd10: d = '{1'b1, GRP_SECTION, 3'd0, 1'b0, 1'b0, CSEL_OUTLINE};
         5'd11: d = '{1'b1, GRP_SECTION, 3'd1, 1'b0, 1'b1, CSEL_OUTLINE};
         5'd12: d = '{1'b1, GRP_SECTION, 3'd2, 1'b1, 1'b1, CSEL_OUTLINE};
         5'd13: d = '{1'b1, GRP_SECTION, 3'd3, 1'b0, 1'b0, CSEL_OUTLINE};
         5'd14: d = '{1'b1, GRP_SECTION, 3'd4, 1'b1, 1'b1, CSEL_OUTLINE};
         5'd15: d = '{1'b1, GRP_SECTION, 3'd5, 1'b1, 1'b0, CSEL_OUTLINE};
         5'd16: d = '{1'b0, GRP_NEXT_JOINT, 3'd0, 1'b1, 1'b0, CSEL_POINT};
         5'd17: d = '{1'b0, GRP_NEXT_JOINT, 3'd1, 1'b1, 1'b0, CSEL_POINT};
         5'd18: d = '{1'b0, GRP_NEXT_JOINT, 3'd2, 1'b1, 1'b1, CSEL_POINT};
         5'd19: d = '{1'b0, GRP_NEXT_JOINT, 3'd3, 1'b1, 1'b0, CSEL_POINT};
         5'd20: d = '{1'b0, GRP_NEXT_JOINT, 3'd4, 1'b1, 1'b1, CSEL_POINT};
         5'd21: d = '{1'b0, GRP_NEXT_JOINT, 3'd5, 1'b1, 1'b0, CSEL_POINT};
         5'd22: d = '{1'b1, GRP_NEXT_JOINT, 3'd0, 1'b1, 1'b0, CSEL_OUTLINE};
         5'd23: d = '{1'b1, GRP_NEXT_JOINT, 3'd1, 1'b1, 1'b0, CSEL_OUTLINE};
         5'd24: d = '{1'b1, GRP_NEXT_JOINT, 3'd2, 1'b1, 1'b1, CSEL_OUTLINE};
         5'd25: d = '{1'b1, GRP_NEXT_JOINT, 3'd3, 1'b1, 1'b0, CSEL_OUTLINE};
         5'd26: d = '{1'b1, GRP_NEXT_JOINT, 3'd4, 1'b1, 1'b1, CSEL_OUTLINE};
         5'd27: d = '{1'b1, GRP_NEXT_JOINT, 3'd5, 1'b1, 1'b0, CSEL_OUTLINE};
         default: d = '{1'b0, GRP_SECTION, 3'd0, 1'b0, 1'b0, CSEL_NONE};
      endcase
      return d;
   endfunction

   // Clamp a widened coordinate to the signed 24-bit range.
   function automatic pos_type sat24(input logic signed [25:0] v);
      pos_type r;
      if (v > POS_MAX) begin
         r = 24'sh7FFFFF;
      end else if (v < POS_MIN) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/tpe_ifs.sv
// Valid/ready channel interfaces of the thick polyline extruder: the point
// request channel and the vertex write channel. Depend on nothing.
interface tpe_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic [31:0]        point_color;
   logic               has_color;

   modport source (output valid, pos_x, pos_y, point_color, has_color, input ready);
   modport sink (input valid, pos_x, pos_y, point_color, has_color, output ready);
endinterface

interface tpe_rsp_if;
   logic               valid;
   logic               ready;
   logic               layer;
   logic [11:0]        vertex_slot;
   logic signed [23:0] vert_x;
   logic signed [23:0] vert_y;
   logic [31:0]        vert_color;
   logic               color_write;
   logic               last;

   modport source (output valid, layer, vertex_slot, vert_x, vert_y, vert_color,
                   color_write, last, input ready);
   modport sink (input valid, layer, vertex_slot, vert_x, vert_y, vert_color,
                 color_write, last, output ready);
endinterface

FILE: hw/rtl/tpe_queue.sv
// Short job queue between the front and the back of the extruder.
// Depends on tpe_pkg for the job type and the queue depth.
module tpe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tpe_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tpe_pkg::job_type pop_data
);
   import tpe_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   job_type          entries_ff [QUEUE_DEPTH];
   job_type          entries_in [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         entries_in[wr_ptr_ff] = push_data;
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/tpe_front.sv
// Front of the extruder: accepts points, applies the store limit and the
// distance test, keeps the previous point and queues segment jobs.
// Depends on tpe_pkg and the tpe_req_if interface.
module tpe_front #(
   parameter int unsigned MAX_POINTS = tpe_pkg::MAX_POINTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   tpe_req_if.sink          req_if,
   input  logic [31:0]      default_color,
   input  logic [15:0]      line_thickness,
   output logic             push_valid,
   input  logic             push_ready,
   output tpe_pkg::job_type push_data
);
   import tpe_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_SQUARE = 3'b010,
      F_DECIDE = 3'b100
   } fstate_type;

   fstate_type         state_ff, state_in;
   pos_type            prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [15:0]        prev_hw_ff, prev_hw_in;
   logic [31:0]        prev_color_ff, prev_color_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   pos_type            bx_ff, bx_in, by_ff, by_in;
   logic [31:0]        bcol_ff, bcol_in;
   logic [15:0]        rb_ff, rb_in;
   logic signed [24:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [48:0]        dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [31:0]        ra2_ff, ra2_in;
   logic signed [49:0] dx_sq, dy_sq;
   logic [49:0]        l2;
   logic               full, first, close, store;

   assign req_if.ready = state_ff == F_IDLE;

   // Squared distance and the classification of the held point.
   always_comb begin
      dx_sq = dx_ff * dx_ff;
      dy_sq = dy_ff * dy_ff;
      l2    = {1'b0, dx2_ff} + {1'b0, dy2_ff};
      full  = count_ff >= CNT_MAX;
      first = count_ff == '0;
      close = l2 <= {18'b0, ra2_ff};
      push_valid = (state_ff == F_DECIDE) && !full && !first && !close;
      store = (state_ff == F_DECIDE) && !full && (first || (!close && push_ready));
   end

   // Job handed to the back.
   always_comb begin
      push_data.ax      = prev_x_ff;
      push_data.ay      = prev_y_ff;
      push_data.bx      = bx_ff;
      push_data.by      = by_ff;
      push_data.dx      = dx_ff;
      push_data.dy      = dy_ff;
      push_data.l2      = l2;
      push_data.ra      = prev_hw_ff;
      push_data.rb      = rb_ff;
      push_data.a_color = prev_color_ff;
      push_data.b_color = bcol_ff;
      push_data.idx     = 12'(count_ff);
      push_data.patch   = count_ff > CNT_ONE;
   end

   // Sequencing of one request and the previous-point update.
   always_comb begin
      state_in      = state_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_hw_in    = prev_hw_ff;
      prev_color_in = prev_color_ff;
      count_in      = count_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      bcol_in       = bcol_ff;
      rb_in         = rb_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dx2_in        = dx2_ff;
      dy2_in        = dy2_ff;
      ra2_in        = ra2_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_if.valid) begin
               bx_in   = req_if.pos_x;
               by_in   = req_if.pos_y;
               bcol_in = req_if.has_color ? req_if.point_color : default_color;
               rb_in   = {1'b0, line_thickness[15:1]};
               dx_in   = {req_if.pos_x[23], req_if.pos_x} - {prev_x_ff[23], prev_x_ff};
               dy_in   = {req_if.pos_y[23], req_if.pos_y} - {prev_y_ff[23], prev_y_ff};
               state_in = F_SQUARE;
            end
         end
         F_SQUARE: begin
            dx2_in   = dx_sq[48:0];
            dy2_in   = dy_sq[48:0];
            ra2_in   = prev_hw_ff * prev_hw_ff;
            state_in = F_DECIDE;
         end
         F_DECIDE: begin
            if (store) begin
               prev_x_in     = bx_ff;
               prev_y_in     = by_ff;
               prev_hw_in    = rb_ff;
               prev_color_in = bcol_ff;
               count_in      = count_ff + 1'b1;
               state_in      = F_IDLE;
            end else if (full || (!first && close)) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      bcol_ff <= bcol_in;
      rb_ff   <= rb_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dx2_ff  <= dx2_in;
      dy2_ff  <= dy2_in;
      ra2_ff  <= ra2_in;
      if (reset) begin
         state_ff      <= F_IDLE;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_hw_ff    <= '0;
         prev_color_ff <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_hw_ff    <= prev_hw_in;
         prev_color_ff <= prev_color_in;
         count_ff      <= count_in;
      end
   end

endmodule

FILE: hw/rtl/tpe_back.sv
// Back of the extruder: segment length by a bit-serial square root, the
// eight normal offsets by a shared multiplier and serial divider, then the
// vertex writes through an output register. Depends on tpe_pkg, tpe_rsp_if.
module tpe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  tpe_pkg::job_type pop_data,
   input  logic [15:0]      outline_thickness,
   input  logic [31:0]      outline_color,
   tpe_rsp_if.source        rsp_if
);
   import tpe_pkg::*;

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_SQRT  = 6'b000010,
      B_MUL   = 6'b000100,
      B_DLOAD = 6'b001000,
      B_DIV   = 6'b010000,
      B_EMIT  = 6'b100000
   } bstate_type;

   typedef struct packed {
      logic signed [18:0] x;
      logic signed [18:0] y;
   } off_pair_type;

   bstate_type         state_ff, state_in;
   job_type            job_ff, job_in;
   logic [63:0]        v_ff, v_in;
   logic [33:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [2:0]         op_ff, op_in;
   logic [41:0]        prod_ff, prod_in;
   logic [31:0]        drem_ff, drem_in;
   logic [17:0]        numlo_ff, numlo_in;
   logic [17:0]        quot_ff, quot_in;
   off_pair_type       off_ff [4];
   off_pair_type       off_in [4];
   logic [4:0]         w_ff, w_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               layer_ff, layer_in, cw_ff, cw_in, last_ff, last_in;
   logic [11:0]        slot_ff, slot_in;
   pos_type            vx_ff, vx_in, vy_ff, vy_in;
   logic [31:0]        color_ff, color_in;

   logic [35:0]        sq_rem2, sq_trial;
   logic [24:0]        mag_c;
   logic [16:0]        rad;
   logic [49:0]        num_w;
   logic [32:0]        d_rem2;
   logic               q_bit, neg;
   logic [17:0]        q_new;
   logic signed [18:0] off_val;
   wr_desc_type        d;
   off_pair_type       o;
   pos_type            base_x, base_y;
   logic signed [25:0] sum_x, sum_y;
   logic               load;

   assign pop_ready          = state_ff == B_IDLE;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.layer       = layer_ff;
   assign rsp_if.vertex_slot = slot_ff;
   assign rsp_if.vert_x      = vx_ff;
   assign rsp_if.vert_y      = vy_ff;
   assign rsp_if.vert_color  = color_ff;
   assign rsp_if.color_write = cw_ff;
   assign rsp_if.last        = last_ff;

   // Datapath of the shared arithmetic units.
   always_comb begin
      // One root bit per step: two radicand bits shift into the remainder.
      sq_rem2  = {rem_ff, v_ff[63:62]};
      sq_trial = {2'b0, root_ff, 2'b01};
      // Operand selection for the current offset.
      mag_c = op_ff[0] ? (job_ff.dx[24] ? -job_ff.dx : job_ff.dx)
                       : (job_ff.dy[24] ? -job_ff.dy : job_ff.dy);
      case (op_ff[2:1])
         2'd0: rad = {1'b0, job_ff.ra};
         2'd1: rad = {1'b0, job_ff.rb};
         2'd2: rad = {1'b0, job_ff.ra} + {1'b0, outline_thickness};
         default: rad = {1'b0, job_ff.rb} + {1'b0, outline_thickness};
      endcase
      // Dividend with the rounding bias of half the divisor.
      num_w = {1'b0, prod_ff, 7'b0} + {19'b0, root_ff[31:1]};
      // Restoring division step.
      d_rem2  = {drem_ff, numlo_ff[17]};
      q_bit   = d_rem2 >= {1'b0, root_ff};
      q_new   = {quot_ff[16:0], q_bit};
      neg     = op_ff[0] ? job_ff.dx[24] : (job_ff.dy > 25'sd0);
      off_val = neg ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});
      // Vertex of the current write.
      d      = wr_desc(w_ff);
      o      = off_ff[{d.layer, d.use_b}];
      base_x = d.use_b ? job_ff.bx : job_ff.ax;
      base_y = d.use_b ? job_ff.by : job_ff.ay;
      sum_x  = d.plus ? ({{2{base_x[23]}}, base_x} + {{7{o.x[18]}}, o.x})
                      : ({{2{base_x[23]}}, base_x} - {{7{o.x[18]}}, o.x});
      sum_y  = d.plus ? ({{2{base_y[23]}}, base_y} + {{7{o.y[18]}}, o.y})
                      : ({{2{base_y[23]}}, base_y} - {{7{o.y[18]}}, o.y});
      load   = (state_ff == B_EMIT) && (!rsp_valid_ff || rsp_if.ready);
   end

   // Job sequencing.
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      v_in     = v_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      prod_in  = prod_ff;
      drem_in  = drem_ff;
      numlo_in = numlo_ff;
      quot_in  = quot_ff;
      off_in   = off_ff;
      w_in     = w_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               job_in   = pop_data;
               v_in     = {pop_data.l2, 14'b0};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = 5'd31;
               state_in = B_SQRT;
            end
         end
         B_SQRT: begin
            v_in = {v_ff[61:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
               rem_in  = 34'(sq_rem2 - sq_trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = sq_rem2[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               op_in    = '0;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prod_in  = mag_c * rad;
            state_in = B_DLOAD;
         end
         B_DLOAD: begin
            drem_in  = num_w[49:18];
            numlo_in = num_w[17:0];
            quot_in  = '0;
            cnt_in   = 5'd17;
            state_in = B_DIV;
         end
         B_DIV: begin
            drem_in  = q_bit ? 32'(d_rem2 - {1'b0, root_ff}) : d_rem2[31:0];
            numlo_in = {numlo_ff[16:0], 1'b0};
            quot_in  = q_new;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (op_ff[0]) begin
                  off_in[op_ff[2:1]].y = off_val;
               end else begin
                  off_in[op_ff[2:1]].x = off_val;
               end
               if (op_ff == 3'd7) begin
                  w_in     = job_ff.patch ? 5'd0 : WR_FIRST_SECTION;
                  state_in = B_EMIT;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = B_MUL;
               end
            end
         end
         B_EMIT: begin
            if (load) begin
               w_in = w_ff + 1'b1;
               if (w_ff == WR_LAST) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Output register of the vertex write channel.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      layer_in     = layer_ff;
      slot_in      = slot_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      color_in     = color_ff;
      cw_in        = cw_ff;
      last_in      = last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         layer_in     = d.layer;
         slot_in      = 12'(job_ff.idx * 12'd12) + 12'({10'b0, d.grp} * 12'd6)
                        + {9'b0, d.k} - 12'd12;
         vx_in        = sat24(sum_x);
         vy_in        = sat24(sum_y);
         cw_in        = d.csel != CSEL_NONE;
         last_in      = w_ff == WR_LAST;
         case (d.csel)
            CSEL_PREV:    color_in = job_ff.a_color;
            CSEL_POINT:   color_in = job_ff.b_color;
            CSEL_OUTLINE: color_in = outline_color;
            default:      color_in = '0;
         endcase
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      v_ff     <= v_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      prod_ff  <= prod_in;
      drem_ff  <= drem_in;
      numlo_ff <= numlo_in;
      quot_ff  <= quot_in;
      off_ff   <= off_in;
      w_ff     <= w_in;
      layer_ff <= layer_in;
      slot_ff  <= slot_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      color_ff <= color_in;
      cw_ff    <= cw_in;
      last_ff  <= last_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/thick_polyline_extruder.sv
// Thick polyline extruder. Points arrive on the request channel; each point
// that survives the store limit and the distance test against the previous
// point turns into up to 28 vertex writes (fill and outline layers) on the
// response channel, the last one flagged. The first point only becomes the
// anchor and produces nothing. The front holds one point at a time and
// waits while the job queue is full; a dropped point never waits. The back
// takes one segment at a time: it loads the job, computes the square root
// one bit per cycle and the 8 offsets on the shared multiplier and serial
// divider, then issues 28 writes, or 24 for the second point, one per cycle
// unless the response channel stalls. The user must write the configuration
// registers on the csr_ port while the block is idle; the block does not
// enforce it. Depends on tpe_pkg, the channel interfaces and tpe_ modules.
module thick_polyline_extruder #(
   parameter int unsigned MAX_POINTS = tpe_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  tpe_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data,
   tpe_req_if.sink                req_if,
   tpe_rsp_if.source              rsp_if
);
   import tpe_pkg::*;

   logic [31:0] default_color_ff, default_color_in;
   logic [15:0] line_thickness_ff, line_thickness_in;
   logic [15:0] outline_thickness_ff, outline_thickness_in;
   logic [31:0] outline_color_ff, outline_color_in;

   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_data, pop_data;

   // Configuration register writes.
   always_comb begin
      default_color_in     = default_color_ff;
      line_thickness_in    = line_thickness_ff;
      outline_thickness_in = outline_thickness_ff;
      outline_color_in     = outline_color_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DEFAULT_COLOR:     default_color_in     = csr_data;
            CSR_LINE_THICKNESS:    line_thickness_in    = csr_data[15:0];
            CSR_OUTLINE_THICKNESS: outline_thickness_in = csr_data[15:0];
            CSR_OUTLINE_COLOR:     outline_color_in     = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_color_ff     <= 32'hFFFF_FFFF;
         line_thickness_ff    <= 16'd256;
         outline_thickness_ff <= '0;
         outline_color_ff     <= '0;
      end else begin
         default_color_ff     <= default_color_in;
         line_thickness_ff    <= line_thickness_in;
         outline_thickness_ff <= outline_thickness_in;
         outline_color_ff     <= outline_color_in;
      end
   end

   tpe_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .default_color  (default_color_ff),
      .line_thickness (line_thickness_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   tpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tpe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .outline_thickness (outline_thickness_ff),
      .outline_color     (outline_color_ff),
      .rsp_if            (rsp_if)
   );

endmodule

FILE: tb/tb_thick_polyline_extruder.sv
// Testbench of the thick polyline extruder: drives polyline points through
// phases of register settings and checks every vertex write against its own
// predictor. Depends on tpe_pkg, the channel interfaces and the block itself.
`timescale 1ns / 1ps

module tb_thick_polyline_extruder;
   import tpe_pkg::*;

   localparam int unsigned STORE_DEPTH = 256;
   localparam int unsigned CYCLE_LIMIT = 8000000;
   localparam int unsigned DRAIN_CYCLES = 600;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [31:0]        color;
      logic               has_color;
   } point_type;

   typedef struct packed {
      logic               layer;
      logic [11:0]        slot;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [31:0]        color;
      logic               color_write;
      logic               last;
   } vertex_type;

   logic clock;
   logic reset;
   logic csr_write;
   csr_index_type csr_index;
   logic [31:0] csr_data;

   tpe_req_if req_bus ();
   tpe_rsp_if rsp_bus ();

   thick_polyline_extruder #(.MAX_POINTS(STORE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   // Pending points, expected vertex writes and run statistics.
   point_type pending_points[$];
   vertex_type expected_vertices[$];
   int unsigned error_count = 0;
   int unsigned segment_count = 0;
   int unsigned dropped_count = 0;
   int unsigned vertex_count = 0;
   int unsigned cycle_count = 0;
   bit no_idle = 1'b0;

   // Shadow of the configuration registers and of the anchor point.
   logic [31:0] sh_default_color;
   logic [15:0] sh_line_thickness;
   logic [15:0] sh_outline_thickness;
   logic [31:0] sh_outline_color;
   logic signed [23:0] anchor_x;
   logic signed [23:0] anchor_y;
   logic [15:0] anchor_half;
   logic [31:0] anchor_color;
   int unsigned stored_points;

   // Last generated point, used to aim points near it.
   logic signed [23:0] last_x = '0;
   logic signed [23:0] last_y = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 200);
   endfunction

   function automatic logic signed [23:0] clamp24(input longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Offset component: comp * r / |d|, rounded half away from zero.
   function automatic longint offset_part(input longint comp, input longint unsigned r,
                                          input longint unsigned s);
      longint unsigned mag;
      longint unsigned q;
      if (s == 0) return 0;
      mag = longint'(comp < 0 ? -comp : comp) * r * 128;
      q = (mag + s / 2) / s;
      return comp < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic void add_vertex(input bit layer, input int unsigned slot,
                                      input longint x, input longint y,
                                      input logic [31:0] color, input bit cw);
      vertex_type v;
      v.layer = layer;
      v.slot = slot[11:0];
      v.x = clamp24(x);
      v.y = clamp24(y);
      v.color = cw ? color : 32'd0;
      v.color_write = cw;
      v.last = 1'b0;
      expected_vertices = {expected_vertices, v};
   endfunction

   // Predict the vertex writes of one accepted point and advance the anchor.
   function automatic void extrude_point(input point_type p);
      longint ax, ay, bx, by, dx, dy;
      longint unsigned l2, s, ra, rb, rao, rbo;
      longint oax, oay, obx, oby, qax, qay, qbx, qby;
      logic [31:0] bcol;
      int unsigned pj, sec, nj;
      bit down;
      bx = p.x;
      by = p.y;
      bcol = p.has_color ? p.color : sh_default_color;
      rb = sh_line_thickness >> 1;
      if (stored_points >= STORE_DEPTH) begin
         dropped_count++;
         return;
      end
      ax = anchor_x;
      ay = anchor_y;
      ra = anchor_half;
      dx = bx - ax;
      dy = by - ay;
      l2 = longint'(dx * dx) + longint'(dy * dy);
      if (stored_points > 0 && l2 <= ra * ra) begin
         dropped_count++;
         return;
      end
      if (stored_points > 0) begin
         s = int_sqrt(l2 << 14);
         rao = ra + sh_outline_thickness;
         rbo = rb + sh_outline_thickness;
         oax = offset_part(-dy, ra, s);  oay = offset_part(dx, ra, s);
         obx = offset_part(-dy, rb, s);  oby = offset_part(dx, rb, s);
         qax = offset_part(-dy, rao, s); qay = offset_part(dx, rao, s);
         qbx = offset_part(-dy, rbo, s); qby = offset_part(dx, rbo, s);
         pj = (2 * stored_points - 2) * 6;
         sec = (2 * stored_points - 1) * 6;
         nj = 2 * stored_points * 6;
         // Position-only patches of the joint before the segment.
         if (stored_points >= 2) begin
            add_vertex(0, pj, ax + oax, ay + oay, 0, 0);
            add_vertex(0, pj + 5, ax - oax, ay - oay, 0, 0);
            add_vertex(1, pj, ax + qax, ay + qay, 0, 0);
            add_vertex(1, pj + 5, ax - qax, ay - qay, 0, 0);
         end
         // Segment quad, fill then outline.
         add_vertex(0, sec, ax - oax, ay - oay, anchor_color, 1);
         add_vertex(0, sec + 1, ax + oax, ay + oay, anchor_color, 1);
         add_vertex(0, sec + 2, bx + obx, by + oby, bcol, 1);
         add_vertex(0, sec + 3, ax - oax, ay - oay, anchor_color, 1);
         add_vertex(0, sec + 4, bx + obx, by + oby, bcol, 1);
         add_vertex(0, sec + 5, bx - obx, by - oby, bcol, 1);
         add_vertex(1, sec, ax - qax, ay - qay, sh_outline_color, 1);
         add_vertex(1, sec + 1, ax + qax, ay + qay, sh_outline_color, 1);
         add_vertex(1, sec + 2, bx + qbx, by + qby, sh_outline_color, 1);
         add_vertex(1, sec + 3, ax - qax, ay - qay, sh_outline_color, 1);
         add_vertex(1, sec + 4, bx + qbx, by + qby, sh_outline_color, 1);
         add_vertex(1, sec + 5, bx - qbx, by - qby, sh_outline_color, 1);
         // Joint after the new point.
         for (int k = 0; k < 6; k++) begin
            down = (k == 2 || k == 4);
            add_vertex(0, nj + k, down ? bx + obx : bx - obx,
                       down ? by + oby : by - oby, bcol, 1);
         end
         for (int k = 0; k < 6; k++) begin
            down = (k == 2 || k == 4);
            add_vertex(1, nj + k, down ? bx + qbx : bx - qbx,
                       down ? by + qby : by - qby, sh_outline_color, 1);
         end
         expected_vertices[expected_vertices.size() - 1].last = 1'b1;
         segment_count++;
      end
      anchor_x = p.x;
      anchor_y = p.y;
      anchor_half = rb[15:0];
      anchor_color = bcol;
      stored_points++;
   endfunction

   // Request driver: holds a point on the bus until it is taken.
   bit holding = 1'b0;
   point_type current_point;
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         holding = 1'b0;
         req_bus.valid <= 1'b0;
      end else begin
         if (holding && req_bus.ready) begin
            extrude_point(current_point);
            holding = 1'b0;
         end
         if (!holding) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_points.size() > 0) begin
               current_point = pending_points.pop_front();
               holding = 1'b1;
               send_gap = pick_gap();
            end
         end
         req_bus.valid <= holding;
         req_bus.pos_x <= current_point.x;
         req_bus.pos_y <= current_point.y;
         req_bus.point_color <= current_point.color;
         req_bus.has_color <= current_point.has_color;
      end
   end

   // Response monitor: checks each write and stalls at random.
   int unsigned stall_left = 0;
   vertex_type seen;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = '{rsp_bus.layer, rsp_bus.vertex_slot, rsp_bus.vert_x, rsp_bus.vert_y,
                     rsp_bus.vert_color, rsp_bus.color_write, rsp_bus.last};
            vertex_count++;
            if (expected_vertices.size() == 0) begin
               error_count++;
               $display("%0t: unexpected write layer=%0d slot=%0d x=%0d y=%0d", $time,
                        seen.layer, seen.slot, seen.x, seen.y);
            end else if (seen !== expected_vertices[0]) begin
               error_count++;
               $display({"%0t: mismatch expected layer=%0d slot=%0d x=%0d y=%0d",
                         " col=%h cw=%0d last=%0d"},
                        $time, expected_vertices[0].layer, expected_vertices[0].slot,
                        expected_vertices[0].x, expected_vertices[0].y,
                        expected_vertices[0].color, expected_vertices[0].color_write,
                        expected_vertices[0].last);
               $display({"%0t:          actual   layer=%0d slot=%0d x=%0d y=%0d",
                         " col=%h cw=%0d last=%0d"},
                        $time, seen.layer, seen.slot, seen.x, seen.y, seen.color,
                        seen.color_write, seen.last);
               void'(expected_vertices.pop_front());
            end else begin
               void'(expected_vertices.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL thick_polyline_extruder");
         $finish;
      end
   end

   task automatic add_point(input logic signed [23:0] x, input logic signed [23:0] y,
                            input logic [31:0] color, input bit has);
      point_type p;
      p = '{x, y, color, has};
      pending_points = {pending_points, p};
      last_x = x;
      last_y = y;
   endtask

   // Random points: mostly far apart, some near or on the last one.
   task automatic add_random_points(input int unsigned count);
      int unsigned r;
      int spread;
      for (int unsigned i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         spread = int'($urandom_range(1, 512));
         if (r < 75) begin
            add_point(24'($urandom), 24'($urandom), $urandom, 1'($urandom_range(0, 1)));
         end else if (r < 85) begin
            add_point(24'(int'(last_x) + int'($urandom_range(0, 2 * spread)) - spread),
                      24'(int'(last_y) + int'($urandom_range(0, 2 * spread)) - spread),
                      $urandom, 1'($urandom_range(0, 1)));
         end else if (r < 95) begin
            add_point(24'(int'(last_x) + int'($urandom_range(0, 200000)) - 100000),
                      24'(int'(last_y) + int'($urandom_range(0, 200000)) - 100000),
                      $urandom, 1'($urandom_range(0, 1)));
         end else begin
            add_point(last_x, last_y, $urandom, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic write_reg(input csr_index_type index, input logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      case (index)
         CSR_DEFAULT_COLOR:     sh_default_color = value;
         CSR_LINE_THICKNESS:    sh_line_thickness = value[15:0];
         CSR_OUTLINE_THICKNESS: sh_outline_thickness = value[15:0];
         default:               sh_outline_color = value;
      endcase
   endtask

   task automatic set_config(input logic [31:0] dcol, input logic [15:0] lt,
                             input logic [15:0] ot, input logic [31:0] ocol);
      write_reg(CSR_DEFAULT_COLOR, dcol);
      write_reg(CSR_LINE_THICKNESS, {16'd0, lt});
      write_reg(CSR_OUTLINE_THICKNESS, {16'd0, ot});
      write_reg(CSR_OUTLINE_COLOR, ocol);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Hold the sender until every write has come and the back has gone quiet.
   task automatic drain();
      while (pending_points.size() > 0 || holding || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus: reset, directed points, then random phases.
   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_DEFAULT_COLOR;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.point_color = '0;
      req_bus.has_color = 1'b0;
      rsp_bus.ready = 1'b0;
      current_point = '0;
      sh_default_color = 32'hFFFF_FFFF;
      sh_line_thickness = 16'd256;
      sh_outline_thickness = 16'd0;
      sh_outline_color = 32'd0;
      anchor_x = '0;
      anchor_y = '0;
      anchor_half = '0;
      anchor_color = '0;
      stored_points = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: first point, coincident and near points, the boundary
      // of the distance test, then coordinate extremes that saturate.
      no_idle = 1'b1;
      add_point(0, 0, 32'h0, 1'b0);
      add_point(0, 0, 32'h0, 1'b1);
      add_point(64, 0, 32'hFFFF_FFFF, 1'b1);
      add_point(128, 0, 32'h1234_5678, 1'b1);
      add_point(129, 0, 32'h0, 1'b1);
      add_point(129, 5000, 32'hFFFF_FFFF, 1'b1);
      add_point(24'sh7FFFFF, 24'sh7FFFFF, 32'hA5A5_5A5A, 1'b0);
      add_point(24'sh800000, 24'sh800000, 32'h0, 1'b1);
      add_point(24'sh7FFFFF, 24'sh800000, 32'hFFFF_FFFF, 1'b1);
      add_point(24'sh800000, 24'sh7FFFFF, 32'h0, 1'b0);
      add_point(-300, 700, 32'h0F0F_F0F0, 1'b1);
      add_point(-300, -700, 32'h0, 1'b0);
      drain();
      no_idle = 1'b0;
      add_random_points(80);
      drain();

      // Widest line and outline.
      set_config(32'h0000_0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      add_point(last_x + 24'sd100, last_y, 32'h0, 1'b0);
      add_point(last_x, last_y + 24'sd40000, 32'h0, 1'b1);
      add_random_points(140);
      drain();

      // Zero width: the distance test drops only coincident points.
      set_config(32'hFFFF_FFFF, 16'd0, 16'd0, 32'h0000_0000);
      add_point(last_x, last_y, 32'h0, 1'b0);
      add_point(last_x + 24'sd1, last_y, 32'h0, 1'b0);
      no_idle = 1'b1;
      add_random_points(60);
      drain();
      no_idle = 1'b0;
      add_random_points(80);
      drain();

      // Random settings; the store is usually full by now, so points are dropped.
      set_config($urandom, 16'($urandom), 16'($urandom_range(0, 2000)), $urandom);
      add_random_points(140);
      drain();

      $display("Ran %0d segments and %0d dropped points, %0d vertex writes checked.",
               segment_count, dropped_count, vertex_count);
      if (error_count == 0) begin
         $display("PASS thick_polyline_extruder");
      end else begin
         $display("FAIL thick_polyline_extruder");
      end
      $finish;
   end

endmodule

FILE: thick_polyline_extruder.f
hw/rtl/tpe_pkg.sv
hw/rtl/tpe_ifs.sv
hw/rtl/tpe_queue.sv
hw/rtl/tpe_front.sv
hw/rtl/tpe_back.sv
hw/rtl/thick_polyline_extruder.sv
tb/tb_thick_polyline_extruder.sv
